// ===== rtl/lmm_pkg.sv =====
// Shared types and constants for the lazy Montgomery modular ALU.
package lmm_pkg;

    // Fixed field widths
    localparam int WORD_W      = 32;
    localparam int VALUE_W     = 31;
    localparam int MOD_W       = 30;
    localparam int PLAIN_W     = 64;
    localparam int MODE_W      = 4;
    localparam int CFG_INDEX_W = 2;

    // Serial datapath: one digit of the multiplier per cycle
    localparam int DIGIT_W     = 4;
    localparam int DIGITS      = WORD_W / DIGIT_W;
    localparam int DIGIT_CNT_W = $clog2(DIGITS);
    localparam int DIV_CNT_W   = $clog2(PLAIN_W);

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_MODULUS     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_NEG_MOD_INV = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_R_SQUARED   = 2'd2;

    // Configuration reset values
    localparam logic [MOD_W-1:0]  MODULUS_RST     = 30'd998244353;
    localparam logic [WORD_W-1:0] NEG_MOD_INV_RST = 32'd998244351;
    localparam logic [MOD_W-1:0]  R_SQUARED_RST   = 30'd932051910;

    // Operation codes
    localparam logic [MODE_W-1:0] MODE_ADD  = 4'd0;
    localparam logic [MODE_W-1:0] MODE_SUB  = 4'd1;
    localparam logic [MODE_W-1:0] MODE_NEG  = 4'd2;
    localparam logic [MODE_W-1:0] MODE_MUL  = 4'd3;
    localparam logic [MODE_W-1:0] MODE_POW  = 4'd4;
    localparam logic [MODE_W-1:0] MODE_INV  = 4'd5;
    localparam logic [MODE_W-1:0] MODE_TO   = 4'd6;
    localparam logic [MODE_W-1:0] MODE_FROM = 4'd7;
    localparam logic [MODE_W-1:0] MODE_EQ   = 4'd8;
    localparam logic [MODE_W-1:0] MODE_LT   = 4'd9;

    typedef struct packed {
        logic [MODE_W-1:0]         mode;
        logic [VALUE_W-1:0]        operand_a;
        logic [VALUE_W-1:0]        operand_b;
        logic signed [PLAIN_W-1:0] plain_value;
        logic [PLAIN_W-1:0]        exponent;
    } lmm_cmd_t;

    typedef struct packed {
        logic [VALUE_W-1:0] result;
        logic               compare_flag;
    } lmm_rsp_t;

    typedef struct packed {
        logic              start;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] product;
    } mul_rsp_t;

    typedef enum logic [1:0] {
        MUL_IDLE,
        MUL_PROD,
        MUL_QUOT,
        MUL_SUM
    } mul_state_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_DIV,
        ST_MUL,
        ST_POW_INIT,
        ST_POW_STEP,
        ST_POW_MUL,
        ST_POW_SQR,
        ST_DONE
    } alu_state_t;

endpackage

// ===== rtl/lmm_if.sv =====
// Command and response channel interfaces of the lazy Montgomery modular ALU.
interface lmm_cmd_if;
    import lmm_pkg::*;

    logic     valid;
    logic     ready;
    lmm_cmd_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface lmm_rsp_if;
    import lmm_pkg::*;

    logic     valid;
    logic     ready;
    lmm_rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/lmm_mont_mul.sv =====
// Digit-serial Montgomery multiplier: product, quotient and reduction passes.
module lmm_mont_mul (
    input  logic                         clk,
    input  logic                         rst_n,
    input  lmm_pkg::mul_req_t            req,
    input  logic [lmm_pkg::MOD_W-1:0]    modulus,
    input  logic [lmm_pkg::WORD_W-1:0]   neg_mod_inverse,
    output lmm_pkg::mul_rsp_t            rsp
);
    import lmm_pkg::*;

    localparam int ACC_W  = WORD_W + 1;
    localparam int PART_W = WORD_W + DIGIT_W;
    localparam int SUM_W  = PART_W + 1;

    mul_state_t             state_reg, state_next;
    logic [DIGIT_CNT_W-1:0] cnt_reg, cnt_next;
    logic [WORD_W-1:0]      mcand_reg, mcand_next;
    logic [WORD_W-1:0]      mplier_reg, mplier_next;
    logic [WORD_W-1:0]      lo_reg, lo_next;
    logic [WORD_W-1:0]      xhi_reg, xhi_next;
    logic [WORD_W-1:0]      prod_reg, prod_next;
    logic [ACC_W-1:0]       hi_reg, hi_next;
    logic                   done_reg, done_next;

    logic [PART_W-1:0]      partial;
    logic [SUM_W-1:0]       step_sum;
    logic [ACC_W-1:0]       step_hi;
    logic [WORD_W-1:0]      step_lo;
    logic                   last_digit;

    // One digit step: add the digit product and the low digit still to be folded in
    assign partial  = {{DIGIT_W{1'b0}}, mcand_reg}
                    * {{WORD_W{1'b0}}, mplier_reg[DIGIT_W-1:0]};
    assign step_sum = SUM_W'(hi_reg) + SUM_W'(partial) + SUM_W'(lo_reg[DIGIT_W-1:0]);
    assign step_hi  = step_sum[SUM_W-1:DIGIT_W];
    assign step_lo  = {step_sum[DIGIT_W-1:0], lo_reg[WORD_W-1:DIGIT_W]};
    assign last_digit = (cnt_reg == DIGIT_CNT_W'(DIGITS - 1));

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        lo_next     = lo_reg;
        xhi_next    = xhi_reg;
        prod_next   = prod_reg;
        hi_next     = hi_reg;
        done_next   = 1'b0;

        case (state_reg)
            MUL_IDLE:
            begin
                if (req.start)
                begin
                    mcand_next  = req.a;
                    mplier_next = req.b;
                    hi_next     = '0;
                    lo_next     = '0;
                    cnt_next    = '0;
                    state_next  = MUL_PROD;
                end
            end
            MUL_PROD, MUL_QUOT, MUL_SUM:
            begin
                hi_next     = step_hi;
                lo_next     = step_lo;
                mplier_next = mplier_reg >> DIGIT_W;
                cnt_next    = cnt_reg + 1'b1;
                if (last_digit)
                begin
                    cnt_next = '0;
                    hi_next  = '0;
                    case (state_reg)
                        MUL_PROD:
                        begin
                            // low half becomes the multiplicand of the quotient pass
                            mcand_next  = step_lo;
                            xhi_next    = step_hi[WORD_W-1:0];
                            mplier_next = neg_mod_inverse;
                            lo_next     = '0;
                            state_next  = MUL_QUOT;
                        end
                        MUL_QUOT:
                        begin
                            // fold the low half back in while adding q * modulus
                            mcand_next  = {{(WORD_W - MOD_W){1'b0}}, modulus};
                            mplier_next = step_lo;
                            lo_next     = mcand_reg;
                            state_next  = MUL_SUM;
                        end
                        default:
                        begin
                            prod_next  = xhi_reg + step_hi[WORD_W-1:0];
                            done_next  = 1'b1;
                            state_next = MUL_IDLE;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = MUL_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MUL_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        lo_reg     <= lo_next;
        xhi_reg    <= xhi_next;
        prod_reg   <= prod_next;
        hi_reg     <= hi_next;
    end

    assign rsp.done    = done_reg;
    assign rsp.product = prod_reg;

endmodule

// ===== rtl/lazy_montgomery_mod_alu_unit.sv =====
// Top level of the lazy Montgomery modular ALU.
//
// Modular arithmetic over an odd modulus below 2^30, values held in Montgomery
// form (R = 2^32) and kept lazily in [0, 2*modulus). One command gives one
// response. Commands are taken one at a time; the response sits in an output
// register so the next command is accepted while it waits to be taken. Add,
// subtract, negate and the compares are worked out in the decode state and go
// straight to the output hand-off. Every Montgomery product goes through one
// shared multiplier that handles one 4-bit digit per cycle over three passes
// (product, quotient, reduction). Multiply and from_mont each take one product;
// to_mont first runs a bit-serial remainder over the 64-bit integer and then
// one product. Power and inverse do one product for the starting value and
// then, per exponent bit, an optional multiply and a squaring. Configuration
// registers must only be written while the unit is idle.
module lazy_montgomery_mod_alu_unit #(
    parameter int EXPONENT_BITS = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    lmm_cmd_if.sink                          cmd,
    lmm_rsp_if.source                        rsp,
    input  logic                             cfg_we,
    input  logic [lmm_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [lmm_pkg::WORD_W-1:0]       cfg_data
);
    import lmm_pkg::*;

    localparam int BIT_CNT_W = $clog2(EXPONENT_BITS + 1);

    function automatic logic [WORD_W-1:0] wrap_fix(input logic [WORD_W-1:0] t,
                                                   input logic [WORD_W-1:0] two_m);
        logic [WORD_W-1:0] fixed;
        fixed = t[WORD_W-1] ? t + two_m : t;
        return fixed;
    endfunction

    // Configuration
    logic [MOD_W-1:0]  modulus_reg;
    logic [WORD_W-1:0] nmi_reg;
    logic [MOD_W-1:0]  r2_reg;

    // Sequencer state and operands
    alu_state_t               state_reg, state_next;
    logic [MODE_W-1:0]        mode_reg, mode_next;
    logic [VALUE_W-1:0]       a_reg, a_next;
    logic [VALUE_W-1:0]       b_reg, b_next;
    logic [PLAIN_W-1:0]       dvd_reg, dvd_next;
    logic                     neg_reg, neg_next;
    logic [EXPONENT_BITS-1:0] exp_reg, exp_next;
    logic [BIT_CNT_W-1:0]     bit_cnt_reg, bit_cnt_next;
    logic [DIV_CNT_W-1:0]     div_cnt_reg, div_cnt_next;
    logic [MOD_W-1:0]         rem_reg, rem_next;
    logic [WORD_W-1:0]        acc_reg, acc_next;
    logic [WORD_W-1:0]        sq_reg, sq_next;
    logic [WORD_W-1:0]        res_reg, res_next;
    logic                     flag_reg, flag_next;

    // Output register
    logic                     out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0]       out_result_reg, out_result_next;
    logic                     out_flag_reg, out_flag_next;
    logic                     out_load;

    // Multiplier hand-off
    mul_req_t mul_req;
    mul_rsp_t mul_rsp;

    // Datapath helpers
    logic [WORD_W-1:0]  m32, two_m, a32, b32, norm_a, norm_b;
    logic [WORD_W-1:0]  m_minus_two, init_val, to_val, from_fix;
    logic [PLAIN_W-1:0] inv_exp_full, plain_bits, plain_mag;
    logic [MOD_W:0]     trial, trial_diff;
    logic               trial_ge;
    logic [MOD_W-1:0]   rem_step;
    logic               pow_last;

    assign m32   = {{(WORD_W - MOD_W){1'b0}}, modulus_reg};
    assign two_m = {{(WORD_W - MOD_W - 1){1'b0}}, modulus_reg, 1'b0};
    assign a32   = {1'b0, a_reg};
    assign b32   = {1'b0, b_reg};

    // Compares act on values brought below modulus by one conditional subtract
    assign norm_a = (a32 >= m32) ? a32 - m32 : a32;
    assign norm_b = (b32 >= m32) ? b32 - m32 : b32;

    // Inverse raises to modulus - 2, taken modulo 2^32
    assign m_minus_two  = m32 - WORD_W'(2);
    assign inv_exp_full = {{(PLAIN_W - WORD_W){1'b0}}, m_minus_two};

    // One in Montgomery form starts from (1 rem modulus) + modulus
    always_comb
    begin
        if (modulus_reg == '0)
            init_val = '0;
        else if (modulus_reg == MOD_W'(1))
            init_val = WORD_W'(1);
        else
            init_val = m32 + WORD_W'(1);
    end

    // Bit-serial remainder of the magnitude of plain_value
    assign plain_bits = cmd.data.plain_value;
    assign plain_mag  = plain_bits[PLAIN_W-1] ? (~plain_bits + PLAIN_W'(1)) : plain_bits;
    assign trial      = {rem_reg, dvd_reg[PLAIN_W-1]};
    assign trial_ge   = (trial >= {1'b0, modulus_reg});
    assign trial_diff = trial - {1'b0, modulus_reg};
    assign rem_step   = trial_ge ? trial_diff[MOD_W-1:0] : trial[MOD_W-1:0];

    // Remainder carries the sign of the integer; lift it into [1, 2*modulus)
    always_comb
    begin
        if (modulus_reg == '0)
            to_val = '0;
        else if (neg_reg)
            to_val = m32 - {{(WORD_W - MOD_W){1'b0}}, rem_step};
        else
            to_val = {{(WORD_W - MOD_W){1'b0}}, rem_step} + m32;
    end

    assign from_fix = (mul_rsp.product >= m32) ? mul_rsp.product - m32 : mul_rsp.product;
    assign pow_last = (bit_cnt_reg == BIT_CNT_W'(EXPONENT_BITS - 1));
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || rsp.ready);

    always_comb
    begin
        state_next   = state_reg;
        mode_next    = mode_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        dvd_next     = dvd_reg;
        neg_next     = neg_reg;
        exp_next     = exp_reg;
        bit_cnt_next = bit_cnt_reg;
        div_cnt_next = div_cnt_reg;
        rem_next     = rem_reg;
        acc_next     = acc_reg;
        sq_next      = sq_reg;
        res_next     = res_reg;
        flag_next    = flag_reg;
        mul_req      = '0;

        case (state_reg)
            ST_IDLE:
            begin
                // Capture the command on transfer
                if (cmd.valid)
                begin
                    mode_next  = cmd.data.mode;
                    a_next     = cmd.data.operand_a;
                    b_next     = cmd.data.operand_b;
                    dvd_next   = plain_mag;
                    neg_next   = plain_bits[PLAIN_W-1];
                    exp_next   = cmd.data.exponent[EXPONENT_BITS-1:0];
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                flag_next = 1'b0;
                res_next  = '0;
                case (mode_reg)
                    MODE_ADD:
                    begin
                        res_next   = wrap_fix(a32 + b32 - two_m, two_m);
                        state_next = ST_DONE;
                    end
                    MODE_SUB:
                    begin
                        res_next   = wrap_fix(a32 - b32, two_m);
                        state_next = ST_DONE;
                    end
                    MODE_NEG:
                    begin
                        res_next   = wrap_fix(WORD_W'(0) - a32, two_m);
                        state_next = ST_DONE;
                    end
                    MODE_MUL:
                    begin
                        mul_req.start = 1'b1;
                        mul_req.a     = a32;
                        mul_req.b     = b32;
                        state_next    = ST_MUL;
                    end
                    MODE_FROM:
                    begin
                        // Reduction of the bare value is a product with one
                        mul_req.start = 1'b1;
                        mul_req.a     = a32;
                        mul_req.b     = WORD_W'(1);
                        state_next    = ST_MUL;
                    end
                    MODE_POW, MODE_INV:
                    begin
                        mul_req.start = 1'b1;
                        mul_req.a     = init_val;
                        mul_req.b     = {{(WORD_W - MOD_W){1'b0}}, r2_reg};
                        sq_next       = a32;
                        bit_cnt_next  = '0;
                        if (mode_reg == MODE_INV)
                            exp_next = inv_exp_full[EXPONENT_BITS-1:0];
                        state_next    = ST_POW_INIT;
                    end
                    MODE_TO:
                    begin
                        rem_next     = '0;
                        div_cnt_next = '0;
                        state_next   = ST_DIV;
                    end
                    MODE_EQ:
                    begin
                        flag_next  = (norm_a == norm_b);
                        state_next = ST_DONE;
                    end
                    MODE_LT:
                    begin
                        flag_next  = (norm_a < norm_b);
                        state_next = ST_DONE;
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_DIV:
            begin
                // One quotient bit per cycle, most significant first
                rem_next     = rem_step;
                dvd_next     = dvd_reg << 1;
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == '1)
                begin
                    mul_req.start = 1'b1;
                    mul_req.a     = to_val;
                    mul_req.b     = {{(WORD_W - MOD_W){1'b0}}, r2_reg};
                    state_next    = ST_MUL;
                end
            end
            ST_MUL:
            begin
                if (mul_rsp.done)
                begin
                    res_next   = (mode_reg == MODE_FROM) ? from_fix : mul_rsp.product;
                    state_next = ST_DONE;
                end
            end
            ST_POW_INIT:
            begin
                if (mul_rsp.done)
                begin
                    acc_next   = mul_rsp.product;
                    state_next = ST_POW_STEP;
                end
            end
            ST_POW_STEP:
            begin
                // Scan the exponent from its least significant bit
                mul_req.start = 1'b1;
                if (exp_reg[0])
                begin
                    mul_req.a  = acc_reg;
                    mul_req.b  = sq_reg;
                    state_next = ST_POW_MUL;
                end
                else
                begin
                    mul_req.a  = sq_reg;
                    mul_req.b  = sq_reg;
                    state_next = ST_POW_SQR;
                end
            end
            ST_POW_MUL:
            begin
                // Multiplier is idle again on the done cycle: chain the squaring
                if (mul_rsp.done)
                begin
                    acc_next      = mul_rsp.product;
                    mul_req.start = 1'b1;
                    mul_req.a     = sq_reg;
                    mul_req.b     = sq_reg;
                    state_next    = ST_POW_SQR;
                end
            end
            ST_POW_SQR:
            begin
                if (mul_rsp.done)
                begin
                    sq_next  = mul_rsp.product;
                    exp_next = exp_reg >> 1;
                    if (pow_last)
                    begin
                        res_next   = acc_reg;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        bit_cnt_next = bit_cnt_reg + 1'b1;
                        state_next   = ST_POW_STEP;
                    end
                end
            end
            ST_DONE:
            begin
                // Hold until the output register is free
                if (out_load)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_result_next = out_result_reg;
        out_flag_next   = out_flag_reg;
        if (out_load)
        begin
            out_valid_next  = 1'b1;
            out_result_next = res_reg[VALUE_W-1:0];
            out_flag_next   = flag_reg;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            modulus_reg   <= MODULUS_RST;
            nmi_reg       <= NEG_MOD_INV_RST;
            r2_reg        <= R_SQUARED_RST;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_MODULUS:     modulus_reg <= cfg_data[MOD_W-1:0];
                    REG_NEG_MOD_INV: nmi_reg     <= cfg_data;
                    REG_R_SQUARED:   r2_reg      <= cfg_data[MOD_W-1:0];
                    default:
                    begin
                        // drop writes to unused indexes
                    end
                endcase
            end
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        mode_reg       <= mode_next;
        a_reg          <= a_next;
        b_reg          <= b_next;
        dvd_reg        <= dvd_next;
        neg_reg        <= neg_next;
        exp_reg        <= exp_next;
        bit_cnt_reg    <= bit_cnt_next;
        div_cnt_reg    <= div_cnt_next;
        rem_reg        <= rem_next;
        acc_reg        <= acc_next;
        sq_reg         <= sq_next;
        res_reg        <= res_next;
        flag_reg       <= flag_next;
        out_result_reg <= out_result_next;
        out_flag_reg   <= out_flag_next;
    end

    lmm_mont_mul u_mont_mul (
        .clk             (clk),
        .rst_n           (rst_n),
        .req             (mul_req),
        .modulus         (modulus_reg),
        .neg_mod_inverse (nmi_reg),
        .rsp             (mul_rsp)
    );

    assign cmd.ready = (state_reg == ST_IDLE);
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = '{result: out_result_reg, compare_flag: out_flag_reg};

    // A product only completes while the sequencer waits for one
    a_done_while_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        mul_rsp.done |-> (state_reg == ST_MUL || state_reg == ST_POW_INIT
                          || state_reg == ST_POW_MUL || state_reg == ST_POW_SQR))
        else $error("multiplier finished outside a wait state");

    a_transfer_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && cmd.ready) |=> (state_reg == ST_START))
        else $error("command transfer did not start decoding");

    a_flag_only_compare: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && flag_reg) |-> (mode_reg == MODE_EQ || mode_reg == MODE_LT))
        else $error("compare flag raised outside a compare");

    a_div_hands_off: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && div_cnt_reg == '1) |=> (state_reg == ST_MUL))
        else $error("remainder pass did not hand off to the multiplier");

endmodule
